// File: rtl/two_wire_segment_display_driver_macros.svh
// assertion macros used by the checker of the display driver
`ifndef TWO_WIRE_SEGMENT_DISPLAY_DRIVER_MACROS_SVH
`define TWO_WIRE_SEGMENT_DISPLAY_DRIVER_MACROS_SVH

// same-cycle implication, held off during reset
`define TWSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define TWSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that is checked through reset too
`define TWSD_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/twsd_pkg.sv
`timescale 1ns / 1ps

package twsd_pkg;

    localparam int DIGITS_DEFAULT = 4;
    localparam int CHARS          = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int IN_DATA_W      = 40;
    localparam int IN_USER_W      = 2;
    localparam int OUT_DATA_W     = 8;
    localparam int KIND_W         = 2;
    localparam int MAX_LEVEL      = 8;

    // item kinds, same codes as the mode field
    typedef enum logic [KIND_W-1:0] {
        K_TICK   = 2'd0,
        K_SHOW   = 2'd1,
        K_BRIGHT = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    localparam logic [7:0] CMD_DATA     = 8'h40;
    localparam logic [7:0] CMD_ADDR     = 8'hC0;
    localparam logic [7:0] CMD_DISP_OFF = 8'h80;
    localparam logic [7:0] CMD_DISP_ON  = 8'h88;

    // ascii digit to segment pattern, blank for anything else
    function automatic logic [7:0] char_to_seg(input logic [7:0] c);
        logic [7:0] seg;
        case (c)
            8'h30:   seg = 8'h3f;
            8'h31:   seg = 8'h06;
            8'h32:   seg = 8'h5b;
            8'h33:   seg = 8'h4f;
            8'h34:   seg = 8'h66;
            8'h35:   seg = 8'h6d;
            8'h36:   seg = 8'h7d;
            8'h37:   seg = 8'h07;
            8'h38:   seg = 8'h7f;
            8'h39:   seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: rtl/twsd_front.sv
`timescale 1ns / 1ps

module twsd_front
    import twsd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
) (
    input  logic                          i_valid,
    input  logic [IN_DATA_W-1:0]          i_data,
    input  logic [IN_USER_W-1:0]          i_user,
    input  logic                          i_queue_ready,
    output logic                          o_ready,
    output logic                          o_push,
    output logic [KIND_W+8+8*DIGITS-1:0]  o_entry
);

    t_kind                 kind;
    logic                  colon;
    logic [3:0]            level;
    logic [3:0]            lsat;
    logic [7:0]            bright_cmd;
    logic [7:0]            byte1;
    logic [8*DIGITS-1:0]   segs;

    assign kind  = t_kind'(i_user[KIND_W-1:0]);
    assign colon = i_data[32];
    assign level = i_data[36:33];

    // brightness command: level zero turns the display off, higher levels saturate at the top step
    always_comb begin
        lsat = (level > 4'(MAX_LEVEL)) ? 4'(MAX_LEVEL) : level;
        if (level == 4'd0) begin
            bright_cmd = CMD_DISP_OFF;
        end else begin
            bright_cmd = CMD_DISP_ON | {4'd0, lsat - 4'd1};
        end
    end

    assign byte1 = (kind == K_BRIGHT) ? bright_cmd : CMD_ADDR;

    for (genvar g = 0; g < DIGITS; g++) begin : g_digit
        logic [7:0] seg;
        if (g < CHARS) begin : g_char
            assign seg = char_to_seg(i_data[g*8 +: 8]);
        end else begin : g_blank
            assign seg = 8'h00;
        end
        // colon sits on the second digit
        if (g == 1) begin : g_colon
            assign segs[g*8 +: 8] = {seg[7] | colon, seg[6:0]};
        end else begin : g_plain
            assign segs[g*8 +: 8] = seg;
        end
    end

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;
    assign o_entry = {segs, byte1, kind};

endmodule

// File: rtl/twsd_queue.sv
`timescale 1ns / 1ps

module twsd_queue
    import twsd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/twsd_back.sv
`timescale 1ns / 1ps

module twsd_back
    import twsd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [KIND_W+8+8*DIGITS-1:0]  i_entry,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [OUT_DATA_W-1:0]         o_out_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BITS,
        PH_ACK,
        PH_STOP
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_clk, n_clk;
    logic                r_dio, n_dio;
    logic [3:0]          r_bit, n_bit;
    logic [2:0]          r_byte, n_byte;
    logic                r_frame, n_frame;
    logic [2:0]          r_len, n_len;
    logic [7:0]          r_byte1;
    logic [8*DIGITS-1:0] r_seg;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_kind               kind;
    logic [7:0]          in_byte1;
    logic [8*DIGITS-1:0] in_segs;
    logic                busy;
    logic                res_busy;
    logic                res_drop;
    logic                load_byte1;
    logic                load_segs;
    logic                do_step;
    logic [2:0]          seg_idx;
    logic [2:0]          byte_inc;
    logic [7:0]          cur_byte;

    assign kind     = t_kind'(i_entry[KIND_W-1:0]);
    assign in_byte1 = i_entry[KIND_W +: 8];
    assign in_segs  = i_entry[KIND_W+8 +: 8*DIGITS];
    assign busy     = (r_phase != PH_IDLE);
    assign do_step  = i_valid && (!r_out_valid || i_out_ready);
    assign seg_idx  = r_byte - 3'd1;
    assign byte_inc = r_byte + 3'd1;

    // byte now on the wire
    always_comb begin
        cur_byte = 8'h00;
        if (!r_frame) begin
            cur_byte = CMD_DATA;
        end else if (r_byte == 3'd0) begin
            cur_byte = r_byte1;
        end else begin
            for (int i = 0; i < DIGITS; i++) begin
                if (seg_idx == 3'(i)) begin
                    cur_byte = r_seg[i*8 +: 8];
                end
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_clk      = r_clk;
        n_dio      = r_dio;
        n_bit      = r_bit;
        n_byte     = r_byte;
        n_frame    = r_frame;
        n_len      = r_len;
        res_busy   = busy;
        res_drop   = 1'b0;
        load_byte1 = 1'b0;
        load_segs  = 1'b0;
        unique case (kind) inside
            K_TICK: begin
                if (busy) begin
                    unique case (r_phase)
                        PH_START: begin
                            n_clk = 1'b1;
                            n_dio = (r_bit == 4'd0);
                            if (r_bit == 4'd0) begin
                                n_bit = 4'd1;
                            end else begin
                                n_bit   = 4'd0;
                                n_byte  = 3'd0;
                                n_phase = PH_BITS;
                            end
                        end
                        PH_BITS: begin
                            n_clk = r_bit[0];
                            n_dio = cur_byte[r_bit[3:1]];
                            if (r_bit == 4'd15) begin
                                n_bit   = 4'd0;
                                n_phase = PH_ACK;
                            end else begin
                                n_bit = r_bit + 4'd1;
                            end
                        end
                        PH_ACK: begin
                            n_clk = (r_bit != 4'd0);
                            n_dio = 1'b1;
                            if (r_bit == 4'd0) begin
                                n_bit = 4'd1;
                            end else begin
                                n_bit   = 4'd0;
                                n_byte  = byte_inc;
                                n_phase = (byte_inc < r_len) ? PH_BITS : PH_STOP;
                            end
                        end
                        PH_STOP: begin
                            unique case (r_bit)
                                4'd0: begin
                                    n_clk = 1'b0;
                                    n_bit = 4'd1;
                                end
                                4'd1: begin
                                    n_clk = 1'b0;
                                    n_dio = 1'b0;
                                    n_bit = 4'd2;
                                end
                                4'd2: begin
                                    n_clk = 1'b1;
                                    n_dio = 1'b0;
                                    n_bit = 4'd3;
                                end
                                default: begin
                                    n_clk  = 1'b1;
                                    n_dio  = 1'b1;
                                    n_bit  = 4'd0;
                                    n_byte = 3'd0;
                                    // address frame follows the data-command frame
                                    if (!r_frame) begin
                                        n_frame = 1'b1;
                                        n_len   = 3'(1 + DIGITS);
                                        n_phase = PH_START;
                                    end else begin
                                        n_phase = PH_IDLE;
                                    end
                                end
                            endcase
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
            K_SHOW, K_BRIGHT: begin
                if (busy) begin
                    res_drop = 1'b1;
                end else begin
                    load_byte1 = 1'b1;
                    load_segs  = (kind == K_SHOW);
                    n_frame    = (kind == K_BRIGHT);
                    n_len      = 3'd1;
                    n_byte     = 3'd0;
                    n_bit      = 4'd0;
                    n_phase    = PH_START;
                    res_busy   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_clk       <= 1'b0;
            r_dio       <= 1'b0;
            r_bit       <= 4'd0;
            r_byte      <= 3'd0;
            r_frame     <= 1'b0;
            r_len       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_step) begin
                r_phase     <= n_phase;
                r_clk       <= n_clk;
                r_dio       <= n_dio;
                r_bit       <= n_bit;
                r_byte      <= n_byte;
                r_frame     <= n_frame;
                r_len       <= n_len;
                r_out_valid <= 1'b1;
                r_out_data  <= {{(OUT_DATA_W-4){1'b0}}, res_drop, res_busy, n_dio, n_clk};
                if (load_byte1) begin
                    r_byte1 <= in_byte1;
                end
                if (load_segs) begin
                    r_seg <= in_segs;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pop       = do_step;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/two_wire_segment_display_driver.sv
`timescale 1ns / 1ps

// two-wire seven-segment display master. every input item gives exactly one
// result item. tuser carries the kind: a tick moves the clk/dio pair on by one
// step of the start / byte / ack / stop sequence, a show request queues the
// data-command frame (0x40) and then the address frame (0xC0 and DIGITS
// segment bytes), a brightness request queues a single display-control frame.
// a request taken while a transfer runs is dropped and flagged in the result.
// rate: one item per clock while the sink keeps taking results. with the queue
// empty, an accepted item is written into the two-entry queue and its result
// is loaded from there into the output register once that register is free. the
// sequencer in the back end steps at most once per clock. while the sink
// stalls, the output register holds its result and the queue takes two more
// items before tready drops on the input side.
module two_wire_segment_display_driver
    import twsd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // char_0, char_1, char_2, char_3, colon_on, level, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // mode
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // clk_level, dio_level, busy_res, dropped, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int ENTRY_W = KIND_W + 8 + 8 * DIGITS;

    // classified item: segment bytes, second command byte, kind
    logic               push;
    logic [ENTRY_W-1:0] push_entry;
    logic               queue_ready;
    logic               queue_valid;
    logic               pop;
    logic [ENTRY_W-1:0] pop_entry;

    // front end: decodes characters and brightness into frame bytes
    twsd_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .i_valid       (i_s_axis_tvalid),
        .i_data        (i_s_axis_tdata),
        .i_user        (i_s_axis_tuser),
        .i_queue_ready (queue_ready),
        .o_ready       (o_s_axis_tready),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // short queue so either side may stall on its own
    twsd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_data  (pop_entry)
    );

    // back end: pin sequencer and output register
    twsd_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// File: rtl/twsd_checker.sv
`timescale 1ns / 1ps

`include "two_wire_segment_display_driver_macros.svh"

module twsd_checker
    import twsd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [IN_USER_W-1:0]  i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // a dropped request only happens while a transfer runs
    `TWSD_ASSERT_NOW(a_drop_busy, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[3], o_m_axis_tdata[2])

    // idle lines rest either both low (after reset) or both high (after stop)
    `TWSD_ASSERT_NOW(a_idle_lines, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[2], o_m_axis_tdata[0] == o_m_axis_tdata[1])

    // a stalled result holds
    `TWSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // nothing is offered right after reset
    `TWSD_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind two_wire_segment_display_driver twsd_checker u_twsd_checker (.*);

// File: dv/twsd_line_checker.sv
`timescale 1ns / 1ps

// watches both streams of the display driver, predicts the line levels and flags
// of every accepted item and compares them with the result items in order
module twsd_line_checker
    import twsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_s_ready,
    // char_0, char_1, char_2, char_3, colon_on, level, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_data,
    // mode
    input  logic [IN_USER_W-1:0]  i_s_user,
    input  logic                  i_m_valid,
    input  logic                  i_m_ready,
    // clk_level, dio_level, busy_res, dropped, zero pad
    input  logic [OUT_DATA_W-1:0] i_m_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_refused
);

    localparam int NDIGITS = DIGITS_DEFAULT;
    localparam int NBYTES  = NDIGITS + 2;
    localparam int COLON_B = 8 * CHARS;
    localparam int LEVEL_B = COLON_B + 1;

    // segment patterns of '9' down to '0'
    localparam logic [79:0] SEG_FONT = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                        8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BITS,
        PH_ACK,
        PH_STOP
    } t_phase;

    // same layout as the low nibble of the result tdata
    typedef struct packed {
        logic dropped;
        logic busy;
        logic dio;
        logic clk;
    } t_pins;

    logic       line_clk;
    logic       line_dio;
    logic [7:0] frame_byte [NBYTES];
    t_phase     phase;
    logic [3:0] bit_pos;
    logic [2:0] byte_pos;
    logic       frame_no;
    logic [2:0] frame_len;

    t_pins      line_results [$];

    function automatic logic [7:0] char_segments(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return SEG_FONT[8 * (c - 8'h30) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic void clear_sequencer();
        line_clk  = 1'b0;
        line_dio  = 1'b0;
        phase     = PH_IDLE;
        bit_pos   = '0;
        byte_pos  = '0;
        frame_no  = 1'b0;
        frame_len = '0;
        for (int i = 0; i < NBYTES; i++) begin
            frame_byte[i] = 8'h00;
        end
    endfunction

    function automatic logic [7:0] byte_on_wire();
        int idx;
        idx = frame_no ? 1 + int'(byte_pos) : 0;
        if (idx >= NBYTES) begin
            return 8'h00;
        end
        return frame_byte[idx];
    endfunction

    // one level pair of the start / bits / ack / stop sequence
    function automatic void step_sequencer();
        logic [3:0] s;
        logic [7:0] cur;
        s = bit_pos;
        case (phase)
            PH_START: begin
                line_clk = 1'b1;
                line_dio = (s == 0);
                if (s == 0) begin
                    bit_pos = 4'd1;
                end else begin
                    bit_pos  = '0;
                    byte_pos = '0;
                    phase    = PH_BITS;
                end
            end
            PH_BITS: begin
                cur      = byte_on_wire();
                line_clk = s[0];
                line_dio = cur[s[3:1]];
                if (s == 4'd15) begin
                    bit_pos = '0;
                    phase   = PH_ACK;
                end else begin
                    bit_pos = s + 4'd1;
                end
            end
            PH_ACK: begin
                line_clk = (s != 0);
                line_dio = 1'b1;
                if (s == 0) begin
                    bit_pos = 4'd1;
                end else begin
                    bit_pos  = '0;
                    byte_pos = byte_pos + 3'd1;
                    phase    = (byte_pos < frame_len) ? PH_BITS : PH_STOP;
                end
            end
            PH_STOP: begin
                if (s == 0) begin
                    line_clk = 1'b0;
                    bit_pos  = 4'd1;
                end else if (s == 1) begin
                    line_clk = 1'b0;
                    line_dio = 1'b0;
                    bit_pos  = 4'd2;
                end else if (s == 2) begin
                    line_clk = 1'b1;
                    line_dio = 1'b0;
                    bit_pos  = 4'd3;
                end else begin
                    line_clk = 1'b1;
                    line_dio = 1'b1;
                    bit_pos  = '0;
                    byte_pos = '0;
                    if (!frame_no) begin
                        // address frame follows the data command
                        frame_no  = 1'b1;
                        frame_len = 3'(1 + NDIGITS);
                        phase     = PH_START;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
            end
            default: phase = PH_IDLE;
        endcase
    endfunction

    function automatic t_pins predict_levels(input t_kind kind,
                                             input logic [IN_DATA_W-1:0] data);
        t_pins      res;
        logic [7:0] seg;
        logic [3:0] lv;
        res.busy    = (phase != PH_IDLE);
        res.dropped = 1'b0;
        case (kind)
            K_TICK: begin
                if (phase != PH_IDLE) begin
                    step_sequencer();
                end
            end
            K_SHOW, K_BRIGHT: begin
                if (phase != PH_IDLE) begin
                    res.dropped = 1'b1;
                end else begin
                    if (kind == K_SHOW) begin
                        frame_byte[0] = CMD_DATA;
                        frame_byte[1] = CMD_ADDR;
                        for (int i = 0; i < NDIGITS; i++) begin
                            seg = (i < CHARS) ? char_segments(data[8 * i +: 8]) : 8'h00;
                            if (i == 1 && data[COLON_B]) begin
                                seg = seg | 8'h80;
                            end
                            frame_byte[2 + i] = seg;
                        end
                        frame_no = 1'b0;
                    end else begin
                        lv = data[LEVEL_B +: 4];
                        if (lv == 0) begin
                            frame_byte[1] = CMD_DISP_OFF;
                        end else begin
                            if (lv > MAX_LEVEL) begin
                                lv = 4'(MAX_LEVEL);
                            end
                            frame_byte[1] = CMD_DISP_ON | 8'(lv - 4'd1);
                        end
                        frame_no = 1'b1;
                    end
                    frame_len = 3'd1;
                    byte_pos  = '0;
                    bit_pos   = '0;
                    phase     = PH_START;
                    res.busy  = 1'b1;
                end
            end
            default: ;
        endcase
        res.clk = line_clk;
        res.dio = line_dio;
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic compare_bit(input string field, input logic want, input logic got);
        if (want !== got) begin
            note_mismatch($sformatf("%s expected %0b, got %0b", field, want, got));
        end
    endtask

    initial begin
        clear_sequencer();
    end

    always @(posedge i_clk) begin : monitor
        t_pins got;
        t_pins want;
        if (!i_rst_n) begin
            clear_sequencer();
            line_results.delete();
        end else begin
            if (i_m_valid && i_m_ready) begin
                got = t_pins'(i_m_data[3:0]);
                if (line_results.size() == 0) begin
                    note_mismatch($sformatf("result item 0x%02h with none expected",
                                            i_m_data));
                end else begin
                    want = line_results.pop_front();
                    compare_bit("clk_level", want.clk, got.clk);
                    compare_bit("dio_level", want.dio, got.dio);
                    compare_bit("busy_res", want.busy, got.busy);
                    compare_bit("dropped", want.dropped, got.dropped);
                    o_checked++;
                end
            end
            if (i_s_valid && i_s_ready) begin
                want = predict_levels(t_kind'(i_s_user), i_s_data);
                if (want.dropped) begin
                    o_refused++;
                end
                line_results.push_back(want);
            end
        end
        o_pending = line_results.size();
    end

endmodule

// File: dv/tb_two_wire_segment_display_driver.sv
`timescale 1ns / 1ps

// stimulus and verdict for the display driver; the checker beside the block
// does all prediction and comparison
module tb_two_wire_segment_display_driver;
    import twsd_pkg::*;

    // ticks to run one frame: start pair, stop sequence, 18 per byte
    localparam int FRAME_OVERHEAD = 6;
    localparam int TICKS_PER_BYTE = 18;
    localparam int BRIGHT_TICKS   = FRAME_OVERHEAD + TICKS_PER_BYTE;
    localparam int SHOW_TICKS     = 2 * FRAME_OVERHEAD
                                    + TICKS_PER_BYTE * (2 + DIGITS_DEFAULT);
    localparam int RANDOM_ITEMS   = 560;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 16;
    // cycles with nothing accepted on either side before giving up
    localparam int IDLE_LIMIT     = 3000;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [IN_USER_W-1:0]  s_user  = '0;
    logic                  m_ready = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_data;

    int mismatches;
    int pending;
    int checked;
    int refused;

    // stimulus controls, the first three shared with the sink process, and counters
    bit gaps_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int sink_stall    = 0;
    int idle_cycles   = 0;
    int items_sent    = 0;
    int kind_count [4];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_wire_segment_display_driver u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    twsd_line_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_refused    (refused)
    );

    // mostly short gaps, now and then a long one, none while gaps are off
    function automatic int pick_gap();
        int r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // fields from the lowest bit up: chars 0..3, colon, level, zero pad
    function automatic logic [IN_DATA_W-1:0] pack_payload(input logic [7:0] c0,
                                                          input logic [7:0] c1,
                                                          input logic [7:0] c2,
                                                          input logic [7:0] c3,
                                                          input logic       colon,
                                                          input logic [3:0] level);
        return {3'b000, level, colon, c3, c2, c1, c0};
    endfunction

    // digits most of the time so the segment font gets exercised
    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 9) < 7) begin
            return 8'h30 + 8'($urandom_range(0, 9));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_payload();
        return pack_payload(rand_char(), rand_char(), rand_char(), rand_char(),
                            1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input t_kind kind, input logic [IN_DATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= data;
        s_user  <= kind;
        @(posedge clk);
        while (!s_ready) begin
            @(posedge clk);
        end
        items_sent++;
        kind_count[kind]++;
    endtask

    task automatic tick_run(input int n);
        repeat (n) begin
            send_item(K_TICK, rand_payload());
        end
    endtask

    // a request followed by ticks, the whole transfer or a cut-short one,
    // with the odd refused request or no-op slipped in between ticks
    task automatic run_transfer(input bit whole);
        t_kind kind;
        int    n;
        kind = ($urandom_range(0, 99) < 60) ? K_SHOW : K_BRIGHT;
        send_item(kind, rand_payload());
        n = (kind == K_SHOW) ? SHOW_TICKS : BRIGHT_TICKS;
        if (!whole) begin
            n = $urandom_range(0, n - 1);
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(t_kind'($urandom_range(1, 3)), rand_payload());
            end
            send_item(K_TICK, rand_payload());
        end
        tick_run($urandom_range(0, 2));
    endtask

    // read at the falling edge, clear of the checker's update
    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin : sink_side
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                sink_stall    = LONG_HOLD;
            end
            if (sink_stall > 0) begin
                m_ready <= 1'b0;
                sink_stall--;
            end else begin
                m_ready <= 1'b1;
                sink_stall = pick_gap();
            end
        end
    end

    // watchdog on cycles in which neither side moves an item
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int random_from;
        int roll;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick and no-op while idle: lines hold, nothing busy
        send_item(K_TICK, pack_payload(8'h30, 8'h31, 8'h32, 8'h33, 1'b0, 4'd0));
        send_item(K_NOP, pack_payload(8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 4'd15));

        // digits 0 to 3 of the font, colon off
        send_item(K_SHOW, pack_payload(8'h30, 8'h31, 8'h32, 8'h33, 1'b0, 4'd0));
        tick_run(SHOW_TICKS);

        // long sink hold while the sender keeps going, so the queue fills and
        // the input stalls; requests during the transfer are refused
        send_item(K_SHOW, pack_payload(8'h34, 8'h35, 8'h36, 8'h37, 1'b1, 4'd3));
        long_hold_req = 1'b1;
        tick_run(30);
        send_item(K_SHOW, pack_payload(8'h38, 8'h39, 8'h30, 8'h31, 1'b0, 4'd0));
        send_item(K_BRIGHT, pack_payload(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 4'd5));
        send_item(K_NOP, pack_payload(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
        tick_run(SHOW_TICKS - 30);

        // characters just outside the digit range and other blanks
        send_item(K_SHOW, pack_payload(8'h38, 8'h39, 8'h2f, 8'h3a, 1'b0, 4'd0));
        tick_run(SHOW_TICKS);
        send_item(K_SHOW, pack_payload(8'h00, 8'hff, 8'h80, 8'h7f, 1'b1, 4'd15));
        tick_run(SHOW_TICKS);

        // brightness: off, lowest, top, and levels that saturate
        foreach (kind_count[i]) begin
        end
        send_item(K_BRIGHT, pack_payload(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
        tick_run(BRIGHT_TICKS);
        send_item(K_BRIGHT, pack_payload(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 4'd1));
        tick_run(BRIGHT_TICKS);
        send_item(K_BRIGHT, pack_payload(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 4'd7));
        tick_run(BRIGHT_TICKS);
        send_item(K_BRIGHT, pack_payload(8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 4'd8));
        tick_run(BRIGHT_TICKS);
        send_item(K_BRIGHT, pack_payload(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 4'd9));
        tick_run(BRIGHT_TICKS);
        send_item(K_BRIGHT, pack_payload(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 4'd15));
        tick_run(BRIGHT_TICKS);

        // sender pause until every result is in
        s_valid <= 1'b0;
        wait_drained();

        // random part: mostly complete transfers, some cut short, some noise
        random_from = items_sent;
        while (items_sent < random_from + RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            roll    = $urandom_range(0, 99);
            if (roll < 80) begin
                run_transfer(1'b1);
            end else if (roll < 90) begin
                run_transfer(1'b0);
            end else begin
                send_item(t_kind'($urandom_range(0, 3)), rand_payload());
            end
        end
        s_valid <= 1'b0;
        gaps_on = 1'b1;

        wait_drained();
        $display("run covered %0d items: %0d show, %0d brightness, %0d tick, %0d no-op",
                 items_sent, kind_count[K_SHOW], kind_count[K_BRIGHT],
                 kind_count[K_TICK], kind_count[K_NOP]);
        $display("%0d results compared, %0d requests refused during a transfer",
                 checked, refused);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
